@@ hw/rtl/mtd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse trie decoder package
// Shared sizes, codes and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package mtd_pkg;

   // Trie geometry: node i has its dot child at 2i+1 and its dash child at 2i+2
   localparam int MAX_CODE_LENGTH = 6;
   localparam int NODE_W          = MAX_CODE_LENGTH + 1;
   localparam int NODE_COUNT      = (2 ** NODE_W) - 1;
   localparam int FIRST_LEAF      = (2 ** MAX_CODE_LENGTH) - 1;
   localparam int STEP_W          = $clog2(MAX_CODE_LENGTH + 1);
   localparam int IDX_W           = $clog2(MAX_CODE_LENGTH);

   // Word field widths
   localparam int LETTER_W    = 8;
   localparam int SYMBOL_W    = 2;
   localparam int CODE_BITS_W = 6;
   localparam int CODE_LEN_W  = 3;

   typedef logic [NODE_W-1:0]   node_type;
   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [STEP_W-1:0]   step_type;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_DECODE = 1'b1
   } action_type;

   typedef enum logic [SYMBOL_W-1:0] {
      SYM_DOT   = 2'd0,
      SYM_DASH  = 2'd1,
      SYM_SPACE = 2'd2,
      SYM_OTHER = 2'd3
   } symbol_type;

   typedef struct packed {
      logic load;        // capture the accepted word
      logic root_write;  // first insert: create the root
      logic walk_step;   // insert: advance one node along the code
      logic leaf_write;  // insert: store the letter at the end node
      logic dec_step;    // decode: apply one symbol
   } mtd_cmd_type;

   typedef struct packed {
      logic op_decode;
      logic root_present;
      logic walk_done;
      logic emit;
   } mtd_status_type;

endpackage

@@ hw/rtl/mtd_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse trie decoder request channel
// Valid/ready channel carrying one insert or decode word.
// ----------------------------------------------------------------------------
interface mtd_req_if import mtd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   action;
   logic [SYMBOL_W-1:0]    symbol;
   logic                   is_final;
   logic [LETTER_W-1:0]    letter;
   logic [CODE_BITS_W-1:0] code_bits;
   logic [CODE_LEN_W-1:0]  code_length;

   modport source (
      output valid, action, symbol, is_final, letter, code_bits, code_length,
      input  ready
   );

   modport sink (
      input  valid, action, symbol, is_final, letter, code_bits, code_length,
      output ready
   );
endinterface

@@ hw/rtl/mtd_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse trie decoder response channel
// Valid/ready channel carrying one decoded letter.
// ----------------------------------------------------------------------------
interface mtd_rsp_if import mtd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [LETTER_W-1:0] decoded_letter;

   modport source (
      output valid, decoded_letter,
      input  ready
   );

   modport sink (
      input  valid, decoded_letter,
      output ready
   );
endinterface

@@ hw/rtl/mtd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse trie decoder controller
// Sequences one word at a time: accept, execute, walk the insert path,
// present the decoded letter.
// ----------------------------------------------------------------------------
module mtd_ctrl import mtd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  mtd_status_type status,
   output mtd_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_WALK = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.op_decode) begin
               cmd.dec_step = 1'b1;
               state_in     = status.emit ? ST_RESP : ST_IDLE;
            end else if (!status.root_present) begin
               cmd.root_write = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.walk_done) begin
               cmd.leaf_write = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/mtd_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse trie decoder datapath
// Node presence bits, letter memory, insert walker and decode state.
// ----------------------------------------------------------------------------
module mtd_datapath import mtd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  mtd_cmd_type            cmd,
   output mtd_status_type         status,
   input  logic                   req_action,
   input  logic [SYMBOL_W-1:0]    req_symbol,
   input  logic                   req_is_final,
   input  logic [LETTER_W-1:0]    req_letter,
   input  logic [CODE_BITS_W-1:0] req_code_bits,
   input  logic [CODE_LEN_W-1:0]  req_code_length,
   input  logic                   csr_write_enable,
   input  logic                   csr_write_data,
   output logic [LETTER_W-1:0]    rsp_decoded_letter
);

   // Captured word
   logic                   action_ff;
   logic [SYMBOL_W-1:0]    symbol_ff;
   logic                   is_final_ff;
   letter_type             letter_ff;
   logic [CODE_BITS_W-1:0] code_bits_ff;
   step_type               len_ff;
   step_type               len_in;

   // Trie store
   logic [NODE_COUNT-1:0]  present_ff;
   logic [NODE_COUNT-1:0]  written_ff;
   letter_type             letter_mem [NODE_COUNT];
   letter_type             rd_letter_ff;
   logic                   rd_written_ff;

   // Insert walker
   node_type               walk_node_ff;
   step_type               step_ff;
   logic [MAX_CODE_LENGTH-1:0] path_bits;
   logic                   walk_bit;
   node_type               walk_child;

   // Decode state
   logic                   cfg_moved_ff;
   node_type               cur_node_ff;
   node_type               cur_node_in;
   logic                   moved_ff;
   logic                   moved_in;
   logic                   start_ff;
   logic                   start_in;
   logic                   is_move;
   logic                   is_space;
   logic                   ends_msg;
   node_type               dec_child;
   logic                   step_moves;
   logic                   moved_new;
   node_type               node_after;

   // Saturate the code length to the trie depth
   always_comb begin
      if (STEP_W'(req_code_length) > STEP_W'(MAX_CODE_LENGTH)) begin
         len_in = STEP_W'(MAX_CODE_LENGTH);
      end else begin
         len_in = STEP_W'(req_code_length);
      end
   end

   // Code positions past the supplied bits read as dots
   for (genvar k = 0; k < MAX_CODE_LENGTH; k++) begin : g_path
      if (k < CODE_BITS_W) begin : g_bit
         assign path_bits[k] = code_bits_ff[k];
      end else begin : g_dot
         assign path_bits[k] = 1'b0;
      end
   end

   assign walk_bit   = path_bits[step_ff[IDX_W-1:0]];
   assign walk_child = {walk_node_ff[NODE_W-2:0], 1'b0} + NODE_W'(1) + NODE_W'(walk_bit);

   // One decode symbol
   always_comb begin
      is_move    = (symbol_ff == SYM_DOT) || (symbol_ff == SYM_DASH);
      is_space   = (symbol_ff == SYM_SPACE);
      ends_msg   = is_final_ff || is_space;
      dec_child  = {cur_node_ff[NODE_W-2:0], 1'b0} + NODE_W'(1) + NODE_W'(symbol_ff[0]);
      step_moves = is_move && (cur_node_ff < NODE_W'(FIRST_LEAF)) && present_ff[dec_child];
      moved_new  = step_moves || (start_ff && cfg_moved_ff);
      node_after = step_moves ? dec_child : cur_node_ff;

      cur_node_in = ends_msg ? '0 : node_after;
      moved_in    = (!ends_msg) && is_move && moved_new;
      start_in    = is_final_ff;
   end

   assign status.op_decode    = (action_ff == ACT_DECODE);
   assign status.root_present = present_ff[0];
   assign status.walk_done    = (step_ff == len_ff);
   assign status.emit         = present_ff[0] &&
                                (is_move ? (is_final_ff && moved_new) : (is_space && moved_ff));

   assign rsp_decoded_letter = rd_written_ff ? rd_letter_ff : '0;

   // Control state and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_moved_ff <= 1'b0;
         present_ff   <= '0;
         written_ff   <= '0;
         cur_node_ff  <= '0;
         moved_ff     <= 1'b0;
         start_ff     <= 1'b1;
      end else begin
         if (csr_write_enable) begin
            cfg_moved_ff <= csr_write_data;
         end
         if (cmd.root_write) begin
            present_ff[0] <= 1'b1;
            written_ff[0] <= 1'b1;
         end
         if (cmd.walk_step) begin
            present_ff[walk_child] <= 1'b1;
         end
         if (cmd.leaf_write) begin
            written_ff[walk_node_ff] <= 1'b1;
         end
         if (cmd.dec_step) begin
            cur_node_ff <= cur_node_in;
            moved_ff    <= moved_in;
            start_ff    <= start_in;
         end
      end
   end

   // Word capture and walker
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff    <= req_action;
         symbol_ff    <= req_symbol;
         is_final_ff  <= req_is_final;
         letter_ff    <= req_letter;
         code_bits_ff <= req_code_bits;
         len_ff       <= len_in;
         walk_node_ff <= '0;
         step_ff      <= '0;
      end else if (cmd.walk_step) begin
         walk_node_ff <= walk_child;
         step_ff      <= step_ff + STEP_W'(1);
      end
   end

   // Letter memory: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.root_write) begin
         letter_mem[0] <= letter_ff;
      end else if (cmd.leaf_write) begin
         letter_mem[walk_node_ff] <= letter_ff;
      end
      if (cmd.dec_step) begin
         rd_letter_ff  <= letter_mem[node_after];
         rd_written_ff <= written_ff[node_after];
      end
   end

endmodule

@@ hw/rtl/morse_trie_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse trie decoder core
// Builds a Morse code trie from insert words and decodes symbol streams.
// ----------------------------------------------------------------------------
// Each request word either inserts a letter with its dot-dash code into the
// trie or decodes one Morse symbol. The block handles one word at a time: a
// decode goes from acceptance through the execute state back to idle, and
// through the respond state as well, held there by any stall, when it returns
// a letter; the first insert after reset only creates the root, and a later
// insert then walks one trie level per cycle for code_length levels (capped at
// 6) before it writes the letter. A decoded letter is read from a
// single-port letter memory with a registered output. Node presence is kept
// in flip-flops cleared by reset, so no clearing pass is needed and the block
// takes words right after reset. csr_write_data sets the moved flag assumed
// for the first symbol of a message; write it only while the block is idle.
// ----------------------------------------------------------------------------
module morse_trie_decoder_core import mtd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mtd_req_if.sink   req_ch,
   mtd_rsp_if.source rsp_ch,
   input  logic      csr_write_enable,
   input  logic      csr_write_data
);

   mtd_cmd_type    cmd;
   mtd_status_type status;

   // Sequencer: accept, execute, walk, respond
   mtd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Trie storage, walker and decode state; the letter holds until taken
   mtd_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_action         (req_ch.action),
      .req_symbol         (req_ch.symbol),
      .req_is_final       (req_ch.is_final),
      .req_letter         (req_ch.letter),
      .req_code_bits      (req_ch.code_bits),
      .req_code_length    (req_ch.code_length),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_decoded_letter (rsp_ch.decoded_letter)
   );

endmodule
